FILE: hdl/edzl_pkg.sv
// EDZL task scheduler: shared types and constants.
// Used by every module of the scheduler; depends on nothing.
package edzl_pkg;

  localparam int unsigned TasksDflt = 16;
  localparam int unsigned ProcW     = 4;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned CountW    = 5;
  localparam logic [ProcW-1:0] ProcRst = 4'd1;

  localparam logic CmdRelease = 1'b0;
  localparam logic CmdTick    = 1'b1;

  localparam logic signed [16:0] DlMin = -17'sd65536;

  typedef enum logic [2:0] {
    PASS_COUNT,
    PASS_ZL,
    PASS_EDF,
    PASS_APPLY,
    PASS_REL
  } pass_e;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  task_slot;
    logic [15:0] rel_deadline;
    logic [15:0] work_ticks;
  } in_item_t;

  typedef struct packed {
    logic [MaskW-1:0]  sched_mask;
    logic [MaskW-1:0]  done_mask;
    logic [MaskW-1:0]  miss_mask;
    logic [CountW-1:0] active_count;
  } out_item_t;

  typedef struct packed {
    logic               active;
    logic               run;
    logic               miss;
    logic signed [16:0] dl;
    logic [15:0]        wk;
  } cell_t;

  typedef struct packed {
    pass_e       pass;
    logic        run_all;
    logic        pend_hit;
    logic        rel_hit;
    logic [15:0] rel_deadline;
    logic [15:0] work_ticks;
  } head_ctl_t;

  typedef struct packed {
    cell_t              nxt;
    logic               eligible;
    logic signed [17:0] key;
    logic               sched;
    logic               done;
  } head_res_t;

endpackage

FILE: hdl/edzl_cell.sv
// EDZL task scheduler: one slot of the rotating task ring.
// Depends on edzl_pkg.
module edzl_cell import edzl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  cell_t d_i,
  output cell_t q_o
);

  cell_t cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q <= d_i;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: hdl/edzl_head.sv
// EDZL task scheduler: update and key logic for the slot at the ring head.
// Depends on edzl_pkg.
module edzl_head import edzl_pkg::*; (
  input  cell_t     cur_i,
  input  head_ctl_t ctl_i,
  output head_res_t res_o
);

  logic signed [17:0] lax;
  logic signed [16:0] dl_n;
  logic [15:0]        wk_n;
  logic               run_n;

  assign lax   = $signed({cur_i.dl[16], cur_i.dl}) - $signed({2'b00, cur_i.wk});
  assign dl_n  = (cur_i.dl != DlMin) ? cur_i.dl - 17'sd1 : cur_i.dl;
  assign wk_n  = (cur_i.wk != 16'd0) ? cur_i.wk - 16'd1 : cur_i.wk;
  assign run_n = cur_i.run || ctl_i.pend_hit || (ctl_i.run_all && cur_i.active);

  always_comb begin
    res_o          = '0;
    res_o.nxt      = cur_i;
    res_o.key      = lax;
    unique case (ctl_i.pass)
      PASS_COUNT: begin
        res_o.nxt.run = 1'b0;
      end
      PASS_ZL, PASS_EDF: begin
        if (ctl_i.pend_hit) begin
          res_o.nxt.run = 1'b1;
        end
        res_o.eligible = cur_i.active && !cur_i.run && !ctl_i.pend_hit;
        if (ctl_i.pass == PASS_EDF) begin
          res_o.key = {cur_i.dl[16], cur_i.dl};
        end
      end
      PASS_APPLY: begin
        res_o.nxt.run = 1'b0;
        if (cur_i.active) begin
          res_o.nxt.dl = dl_n;
          if (run_n) begin
            res_o.sched  = 1'b1;
            res_o.nxt.wk = wk_n;
            if (wk_n == 16'd0) begin
              res_o.done       = 1'b1;
              res_o.nxt.active = 1'b0;
              if (dl_n[16]) begin
                res_o.nxt.miss = 1'b1;
              end
            end
          end
        end
      end
      PASS_REL: begin
        if (ctl_i.rel_hit) begin
          res_o.nxt.dl     = $signed({1'b0, ctl_i.rel_deadline});
          res_o.nxt.wk     = ctl_i.work_ticks;
          res_o.nxt.active = (ctl_i.work_ticks != 16'd0);
          if (ctl_i.rel_deadline < ctl_i.work_ticks) begin
            res_o.nxt.miss = 1'b1;
          end
        end
      end
      default: begin
        res_o.nxt = cur_i;
      end
    endcase
  end

endmodule

FILE: hdl/edzl_task_scheduler_unit.sv
// EDZL task scheduler top level: ring of slot cells, head logic and sequencer.
// Depends on edzl_pkg, edzl_cell and edzl_head.
//
// Usage: items enter on in_valid_i/in_stall_o as in_item_t, results leave on
// out_valid_o/out_stall_i as out_item_t, one result per item. The processor
// count is written on cfg_valid_i/cfg_ready_o; the user must write it only
// while the block is idle; the block does not enforce this. The slot table
// is a ring of TASKS cells rotating past one head unit. A release takes
// one release pass, then its result goes to the output register.
// A tick takes one counting pass, then one selection pass per picked task plus
// at most one failed zero-laxity pass, then one update pass, then its result
// goes to the output register.
// One item is worked at a time; in_stall_o is high while an item is in work.
// The next item is taken while a finished result waits in the output register;
// if the receiver stalls, the following result waits internally until the
// output register frees.
// Reset clears every slot, all miss flags and sets processors to 1.
module edzl_task_scheduler_unit import edzl_pkg::*; #(
  parameter int unsigned TASKS = TasksDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ProcW-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(TASKS);
  localparam int unsigned AW = $clog2(TASKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  state_e             state_q;
  pass_e              pass_q;
  logic [ProcW-1:0]   proc_q;
  in_item_t           in_q;
  logic [IW-1:0]      cnt_q;
  logic [AW-1:0]      act_q, act_d;
  logic               run_all_q;
  logic               bf_q, bf_d;
  logic signed [17:0] bk_q, bk_d;
  logic [IW-1:0]      bi_q, bi_d;
  logic               pend_q;
  logic [IW-1:0]      pidx_q;
  logic [ProcW-1:0]   picked_q;
  logic [MaskW-1:0]   sched_q, done_q, miss_q;
  logic [MaskW-1:0]   sched_d, done_d, miss_d, bit_at;
  out_item_t          res_q, res_d;
  logic               out_valid_q;
  out_item_t          out_q;

  cell_t              ring [TASKS];
  head_ctl_t          ctl;
  head_res_t          hres;
  logic               shift;
  logic               last;
  logic               take;
  logic [ProcW:0]     picked_inc;
  logic [7:0]         act_ext;
  logic [CountW-1:0]  act_sat;

  assign shift = (state_q == ST_RUN);

  for (genvar i = 0; i < TASKS; i++) begin : g_ring
    cell_t d;
    if (i == TASKS - 1) begin : g_tail
      assign d = hres.nxt;
    end else begin : g_mid
      assign d = ring[i+1];
    end
    edzl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (d),
      .q_o     (ring[i])
    );
  end

  assign ctl.pass         = pass_q;
  assign ctl.run_all      = run_all_q;
  assign ctl.pend_hit     = pend_q && (pidx_q == cnt_q);
  assign ctl.rel_hit      = (7'(in_q.task_slot) == 7'(cnt_q));
  assign ctl.rel_deadline = in_q.rel_deadline;
  assign ctl.work_ticks   = in_q.work_ticks;

  edzl_head u_head (
    .cur_i (ring[0]),
    .ctl_i (ctl),
    .res_o (hres)
  );

  assign last       = (cnt_q == IW'(TASKS - 1));
  assign bit_at     = MaskW'(1) << cnt_q;
  assign take       = hres.eligible && (!bf_q || (hres.key < bk_q));
  assign bf_d       = bf_q || take;
  assign bk_d       = take ? hres.key : bk_q;
  assign bi_d       = take ? cnt_q : bi_q;
  assign picked_inc = {1'b0, picked_q} + 5'd1;
  assign sched_d    = hres.sched ? (sched_q | bit_at) : sched_q;
  assign done_d     = hres.done ? (done_q | bit_at) : done_q;
  assign miss_d     = hres.nxt.miss ? (miss_q | bit_at) : miss_q;

  always_comb begin
    act_d = act_q;
    if (pass_q == PASS_COUNT && ring[0].active) begin
      act_d = act_q + AW'(1);
    end else if (pass_q == PASS_REL && hres.nxt.active) begin
      act_d = act_q + AW'(1);
    end
  end

  assign act_ext = 8'(act_d);
  assign act_sat = (act_ext > 8'd31) ? 5'd31 : 5'(act_ext);

  always_comb begin
    res_d              = '0;
    res_d.miss_mask    = miss_d;
    res_d.active_count = act_sat;
    if (pass_q == PASS_APPLY) begin
      res_d.sched_mask   = sched_d;
      res_d.done_mask    = done_d;
      res_d.active_count = 5'(act_q > AW'(31) ? 31 : act_q);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_COUNT;
      proc_q      <= ProcRst;
      in_q        <= '0;
      cnt_q       <= '0;
      act_q       <= '0;
      run_all_q   <= 1'b0;
      bf_q        <= 1'b0;
      bk_q        <= '0;
      bi_q        <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      picked_q    <= '0;
      sched_q     <= '0;
      done_q      <= '0;
      miss_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        proc_q <= cfg_data_i;
      end
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q      <= in_data_i;
            pass_q    <= (in_data_i.cmd == CmdTick) ? PASS_COUNT : PASS_REL;
            cnt_q     <= '0;
            act_q     <= '0;
            run_all_q <= 1'b0;
            bf_q      <= 1'b0;
            pend_q    <= 1'b0;
            picked_q  <= '0;
            sched_q   <= '0;
            done_q    <= '0;
            miss_q    <= '0;
            state_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_q <= last ? '0 : cnt_q + IW'(1);
          if (pass_q == PASS_COUNT || pass_q == PASS_REL) begin
            act_q <= act_d;
          end
          sched_q <= sched_d;
          done_q  <= done_d;
          miss_q  <= miss_d;
          bf_q    <= last ? 1'b0 : bf_d;
          bk_q    <= bk_d;
          bi_q    <= bi_d;
          if (last) begin
            unique case (pass_q)
              PASS_COUNT: begin
                if (8'(act_d) <= 8'(proc_q)) begin
                  run_all_q <= 1'b1;
                  pass_q    <= PASS_APPLY;
                end else if (proc_q == '0) begin
                  pass_q <= PASS_APPLY;
                end else begin
                  pass_q <= PASS_ZL;
                end
              end
              PASS_ZL: begin
                if (bf_d && (bk_d <= 18'sd0)) begin
                  pend_q   <= 1'b1;
                  pidx_q   <= bi_d;
                  picked_q <= picked_inc[ProcW-1:0];
                  pass_q   <= (picked_inc < {1'b0, proc_q}) ? PASS_ZL : PASS_APPLY;
                end else begin
                  pend_q <= 1'b0;
                  pass_q <= PASS_EDF;
                end
              end
              PASS_EDF: begin
                if (bf_d) begin
                  pend_q   <= 1'b1;
                  pidx_q   <= bi_d;
                  picked_q <= picked_inc[ProcW-1:0];
                  pass_q   <= (picked_inc < {1'b0, proc_q}) ? PASS_EDF : PASS_APPLY;
                end else begin
                  pend_q <= 1'b0;
                  pass_q <= PASS_APPLY;
                end
              end
              PASS_APPLY, PASS_REL: begin
                pend_q  <= 1'b0;
                res_q   <= res_d;
                state_q <= ST_OUT;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> (cnt_q == '0))
    else $error("ring position not at rest outside a pass");

  a_done_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.done_mask & ~out_data_o.sched_mask) == '0))
    else $error("finished slot that did not run");

  a_sched_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(out_data_o.sched_mask) <= 32'(proc_q)))
    else $error("more slots scheduled than processors");

  a_picked_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && (pass_q == PASS_ZL || pass_q == PASS_EDF))
      |-> (picked_q < proc_q))
    else $error("selection pass with no free processor");
`endif

endmodule

FILE: verif/tb_edzl_task_scheduler_unit.sv
// Testbench for edzl_task_scheduler_unit: directed table, then random releases and ticks,
// checked against an in-bench EDZL predictor. Depends on edzl_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_edzl_task_scheduler_unit;
  import edzl_pkg::*;

  localparam int NSLOT = 16;
  localparam int LIMIT = 4000000;

  typedef struct {
    in_item_t  item;
    logic      chk;
    out_item_t want;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [ProcW-1:0] cfg_data;

  edzl_task_scheduler_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // predictor state
  int unsigned n_proc;
  logic        act[NSLOT];
  int          dl_left[NSLOT];
  int          wk_left[NSLOT];
  logic        missed[NSLOT];

  out_item_t sched_expq[$];
  int errors, cycles;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_edzl_task_scheduler_unit: FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h exp %0h", what, got, exp);
    errors++;
  endtask

  function automatic int lax(int s);
    return dl_left[s] - wk_left[s];
  endfunction

  function automatic out_item_t edzl_step(in_item_t it);
    out_item_t r;
    logic run[NSLOT], seen[NSLOT];
    int unsigned cnt, picked;
    int best;
    r = '0;
    cnt = 0;
    picked = 0;
    foreach (run[s]) begin run[s] = 0; seen[s] = 0; end
    if (it.cmd == CmdRelease) begin
      dl_left[it.task_slot] = it.rel_deadline;
      wk_left[it.task_slot] = it.work_ticks;
      act[it.task_slot] = (it.work_ticks != 0);
      if (int'(it.rel_deadline) < int'(it.work_ticks)) missed[it.task_slot] = 1;
      foreach (act[s]) if (act[s]) cnt++;
    end else begin
      foreach (act[s]) if (act[s]) cnt++;
      if (cnt > n_proc) begin
        for (int k = 0; k < n_proc; k++) begin
          best = -1;
          for (int s = 0; s < NSLOT; s++)
            if (act[s] && !seen[s] && (best < 0 || lax(s) < lax(best))) best = s;
          if (best < 0 || lax(best) > 0) break;
          seen[best] = 1;
          run[best] = 1;
          picked++;
        end
        while (picked < n_proc) begin
          best = -1;
          for (int s = 0; s < NSLOT; s++)
            if (act[s] && !run[s] && (best < 0 || dl_left[s] < dl_left[best])) best = s;
          if (best < 0) break;
          run[best] = 1;
          picked++;
        end
      end else begin
        foreach (act[s]) run[s] = act[s];
      end
      for (int s = 0; s < NSLOT; s++) begin
        if (!act[s]) continue;
        if (dl_left[s] > -65536) dl_left[s]--;
        if (run[s]) begin
          r.sched_mask[s] = 1;
          if (wk_left[s] > 0) wk_left[s]--;
          if (wk_left[s] == 0) begin
            r.done_mask[s] = 1;
            act[s] = 0;
            if (dl_left[s] < 0) missed[s] = 1;
          end
        end
      end
    end
    foreach (missed[s]) r.miss_mask[s] = missed[s];
    r.active_count = (cnt > 31) ? 5'd31 : 5'(cnt);
    return r;
  endfunction

  // result side
  initial begin
    int w;
    out_item_t e;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      w = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (sched_expq.size() == 0) begin
        report("unexpected result", 64'(out_data), 64'(0));
      end else begin
        e = sched_expq.pop_front();
        if (out_data.sched_mask !== e.sched_mask)
          report("sched_mask", 64'(out_data.sched_mask), 64'(e.sched_mask));
        if (out_data.done_mask !== e.done_mask)
          report("done_mask", 64'(out_data.done_mask), 64'(e.done_mask));
        if (out_data.miss_mask !== e.miss_mask)
          report("miss_mask", 64'(out_data.miss_mask), 64'(e.miss_mask));
        if (out_data.active_count !== e.active_count)
          report("active_count", 64'(out_data.active_count), 64'(e.active_count));
      end
    end
  end

  task automatic send(input in_item_t it, input logic chk, input out_item_t want);
    out_item_t p;
    int w;
    w = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = edzl_step(it);
    if (chk && p !== want) report("directed row", 64'(p), 64'(want));
    sched_expq.push_back(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sched_expq.size() != 0) @(posedge clk);
    repeat (12 * NSLOT) @(posedge clk);
  endtask

  task automatic set_proc(input int unsigned n);
    drain();
    cfg_data <= ProcW'(n);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_proc = n;
  endtask

  function automatic in_item_t mk(logic c, int sl, int d, int w);
    in_item_t it;
    it.cmd = c;
    it.task_slot = 4'(sl);
    it.rel_deadline = 16'(d);
    it.work_ticks = 16'(w);
    return it;
  endfunction

  function automatic out_item_t ow(int sm, int dm, int mm, int ac);
    out_item_t o;
    o.sched_mask = MaskW'(sm);
    o.done_mask = MaskW'(dm);
    o.miss_mask = MaskW'(mm);
    o.active_count = CountW'(ac);
    return o;
  endfunction

  task automatic add(in_item_t it, logic chk = 0, out_item_t want = '0);
    row_t r;
    r.item = it;
    r.chk = chk;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic rand_item(input int maxw);
    in_item_t it;
    int d, w;
    if ($urandom_range(0, 99) < 55) begin
      it = mk(CmdTick, $urandom, $urandom, $urandom);
    end else begin
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, maxw);
      case ($urandom_range(0, 4))
        0: d = $urandom_range(0, 65535);
        1: d = w;
        default: d = w + $urandom_range(0, 3 * maxw);
      endcase
      if (d > 65535) d = 65535;
      it = mk(CmdRelease, $urandom_range(0, 15), d, w);
    end
    send(it, 0, '0);
  endtask

  initial begin
    int unsigned procs[6];
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    n_proc = ProcRst;
    foreach (act[s]) begin act[s] = 0; dl_left[s] = 0; wk_left[s] = 0; missed[s] = 0; end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add(mk(CmdTick, 0, 0, 0), 1, ow(0, 0, 0, 0));
    add(mk(CmdRelease, 0, 65535, 65535), 1, ow(0, 0, 0, 1));
    add(mk(CmdRelease, 15, 1, 2), 1, ow(0, 0, 16'h8000, 2));
    add(mk(CmdRelease, 3, 5, 0), 1, ow(0, 0, 16'h8000, 2));
    add(mk(CmdRelease, 4, 3, 1));
    add(mk(CmdRelease, 5, 4, 4));
    add(mk(CmdTick, 0, 0, 0));
    add(mk(CmdTick, 9, 16'hffff, 16'hffff));
    add(mk(CmdRelease, 5, 0, 0));
    add(mk(CmdTick, 0, 0, 0));
    add(mk(CmdTick, 0, 0, 0));
    add(mk(CmdRelease, 7, 16'haaaa, 16'h5555));
    add(mk(CmdRelease, 8, 16'h5555, 16'haaaa));
    add(mk(CmdTick, 0, 0, 0));
    foreach (rows[i]) send(rows[i].item, rows[i].chk, rows[i].want);

    set_proc(0);
    repeat (4) send(mk(CmdTick, 0, 0, 0), 0, '0);
    set_proc(15);
    for (int s = 0; s < 16; s++) send(mk(CmdRelease, s, 3 + s, 2), 0, '0);
    repeat (3) send(mk(CmdTick, 0, 0, 0), 0, '0);
    set_proc(8);
    for (int s = 0; s < 16; s++) send(mk(CmdRelease, s, 1 + s, 1 + (s % 3)), 0, '0);
    repeat (6) send(mk(CmdTick, 0, 0, 0), 0, '0);

    procs = '{1, 2, 3, 4, 8, 5};
    foreach (procs[p]) begin
      set_proc(procs[p]);
      for (int i = 0; i < 310; i++) rand_item((i % 50 == 7) ? 200 : 12);
    end
    // slot table left to run into underflow territory is too slow; one aging run at 0 procs
    set_proc(0);
    for (int i = 0; i < 60; i++) rand_item(12);
    set_proc(1);
    drain();
    if (errors == 0) begin
      $display("tb_edzl_task_scheduler_unit: PASS");
    end else begin
      $display("tb_edzl_task_scheduler_unit: FAIL");
    end
    $finish;
  end

endmodule
